FILE: design/miller_rabin_prime_test_32_core_assert.svh
// Assertion macros shared by the prime test core and its multiplier.
`ifndef MILLER_RABIN_PRIME_TEST_32_CORE_ASSERT_SVH
`define MILLER_RABIN_PRIME_TEST_32_CORE_ASSERT_SVH

// Same-cycle implication, clocked on clk, disabled in reset.
`define MRPT_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, disabled in reset.
`define MRPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/mrpt_pkg.sv
// Package: shared constants, witness table and controller state type.
`timescale 1ns / 1ps

package mrpt_pkg;

    // Default candidate width
    localparam int unsigned NUM_WIDTH_DEF = 32;

    // Small primes handled directly
    localparam int unsigned PRIME_TWO   = 2;
    localparam int unsigned PRIME_THREE = 3;

    // Witness set, exact for all 32-bit candidates
    localparam int unsigned WITNESS_COUNT = 3;
    localparam logic [1:0]  WIT_LAST      = 2'(WITNESS_COUNT - 1);

    typedef enum logic [1:0] {
        WIT_IDX_A = 2'd0,
        WIT_IDX_B = 2'd1,
        WIT_IDX_C = 2'd2
    } wit_idx_t;

    // Witness value for a witness index
    function automatic logic [7:0] witness_of(input logic [1:0] idx);
        logic [7:0] w;
        case (idx)
            WIT_IDX_A: w = 8'd2;
            WIT_IDX_B: w = 8'd7;
            WIT_IDX_C: w = 8'd61;
            default:   w = 8'd2;
        endcase
        return w;
    endfunction

    // Controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_PREP,
        ST_BASE,
        ST_SKIP,
        ST_STEP,
        ST_SQR,
        ST_MULB,
        ST_TEST,
        ST_CHAIN
    } state_t;

endpackage

FILE: design/miller_rabin_prime_test_32_core.sv
// Top level: deterministic Miller-Rabin prime test with witnesses 2, 7 and 61.
//
// A candidate is taken when start is high and busy is low; its low NUM_WIDTH
// bits are tested. Exactly one result follows: is_prime is valid in the single
// cycle in which done is high, and must be captured then, as the result cannot
// be held back. Trivial cases (below 2, 2, 3, even) finish without the screen;
// everything else first runs a serial screen over all NUM_WIDTH bits (residue
// mod 3 and the split n-1 = d * 2^e). Each witness then costs one base reduction
// plus one modular multiply per squaring and per set bit of d, at most about
// 2*NUM_WIDTH multiplies, each a full pass of the bit-serial multiplier;
// composites usually stop after one witness. The multiplier, which takes
// one bit of its second operand per cycle, dominates the run time.
`timescale 1ns / 1ps
`include "miller_rabin_prime_test_32_core_assert.svh"

module miller_rabin_prime_test_32_core
    import mrpt_pkg::*;
#(
    parameter int unsigned NUM_WIDTH = NUM_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] candidate,
    output logic        done,
    output logic        is_prime
);

    localparam int unsigned CW = $clog2(NUM_WIDTH + 1);
    localparam int unsigned EW = $clog2(NUM_WIDTH);

    localparam logic [NUM_WIDTH-1:0] N_ONE   = NUM_WIDTH'(1);
    localparam logic [NUM_WIDTH-1:0] N_TWO   = NUM_WIDTH'(PRIME_TWO);
    localparam logic [NUM_WIDTH-1:0] N_THREE = NUM_WIDTH'(PRIME_THREE);
    localparam logic [NUM_WIDTH-1:0] N_WIT_B = NUM_WIDTH'(witness_of(WIT_IDX_B));
    localparam logic [NUM_WIDTH-1:0] N_WIT_C = NUM_WIDTH'(witness_of(WIT_IDX_C));

    state_t               state_reg, state_next;
    logic [NUM_WIDTH-1:0] n_reg, n_next;
    logic [NUM_WIDTH-1:0] base_reg, base_next;
    logic [NUM_WIDTH-1:0] acc_reg, acc_next;
    logic [NUM_WIDTH-1:0] exp_reg, exp_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [EW-1:0]        ch_reg, ch_next;
    logic [1:0]           wit_reg, wit_next;
    logic                 done_reg, done_next;
    logic                 res_reg, res_next;

    logic [NUM_WIDTH-1:0] nm1;
    logic                 wit_pass, wit_fail;

    // Multiplier and screen hookup
    logic                 mm_start, mm_done;
    logic [NUM_WIDTH-1:0] mm_a, mm_b, mm_prod;
    logic                 prep_start, prep_done, prep_div3;
    logic [NUM_WIDTH-1:0] prep_d;
    logic [EW-1:0]        prep_e;

    mrpt_modmul #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_modmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mm_start),
        .a     (mm_a),
        .b     (mm_b),
        .m     (n_reg),
        .done  (mm_done),
        .prod  (mm_prod)
    );

    mrpt_prep #(
        .NUM_WIDTH (NUM_WIDTH)
    ) u_prep (
        .clk   (clk),
        .rst_n (rst_n),
        .start (prep_start),
        .n     (n_reg),
        .done  (prep_done),
        .div3  (prep_div3),
        .d     (prep_d),
        .e     (prep_e)
    );

    assign nm1 = n_reg - N_ONE;

    // Next state and datapath control
    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        base_next  = base_reg;
        acc_next   = acc_reg;
        exp_next   = exp_reg;
        cnt_next   = cnt_reg;
        ch_next    = ch_reg;
        wit_next   = wit_reg;
        done_next  = 1'b0;
        res_next   = res_reg;
        mm_start   = 1'b0;
        mm_a       = acc_reg;
        mm_b       = acc_reg;
        prep_start = 1'b0;
        wit_pass   = 1'b0;
        wit_fail   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    n_next     = candidate[NUM_WIDTH-1:0];
                    state_next = ST_CHECK;
                end
            end

            // Trivial cases straight from the value
            ST_CHECK:
            begin
                if (n_reg < N_TWO)
                begin
                    done_next  = 1'b1;
                    res_next   = 1'b0;
                    state_next = ST_IDLE;
                end
                else if (n_reg inside {N_TWO, N_THREE})
                begin
                    done_next  = 1'b1;
                    res_next   = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (!n_reg[0])
                begin
                    done_next  = 1'b1;
                    res_next   = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    prep_start = 1'b1;
                    state_next = ST_PREP;
                end
            end

            // Wait for screen; then reduce the first witness mod n
            ST_PREP:
            begin
                if (prep_done)
                begin
                    if (prep_div3)
                    begin
                        done_next  = 1'b1;
                        res_next   = 1'b0;
                        state_next = ST_IDLE;
                    end
                    else if (n_reg inside {N_WIT_B, N_WIT_C})
                    begin
                        done_next  = 1'b1;
                        res_next   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        wit_next   = WIT_IDX_A;
                        mm_start   = 1'b1;
                        mm_a       = N_ONE;
                        mm_b       = NUM_WIDTH'(witness_of(WIT_IDX_A));
                        state_next = ST_BASE;
                    end
                end
            end

            // Witness residue ready: load exponent
            ST_BASE:
            begin
                if (mm_done)
                begin
                    base_next  = mm_prod;
                    exp_next   = prep_d;
                    cnt_next   = CW'(NUM_WIDTH);
                    state_next = ST_SKIP;
                end
            end

            // Drop leading zeros of d, one bit per cycle
            ST_SKIP:
            begin
                if (exp_reg[NUM_WIDTH-1])
                begin
                    acc_next   = N_ONE;
                    state_next = ST_STEP;
                end
                else
                begin
                    exp_next = {exp_reg[NUM_WIDTH-2:0], 1'b0};
                    cnt_next = cnt_reg - CW'(1);
                end
            end

            // Next exponent bit: square the accumulator
            ST_STEP:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_TEST;
                end
                else
                begin
                    mm_start   = 1'b1;
                    state_next = ST_SQR;
                end
            end

            ST_SQR:
            begin
                if (mm_done)
                begin
                    acc_next = mm_prod;
                    if (exp_reg[NUM_WIDTH-1])
                    begin
                        mm_start   = 1'b1;
                        mm_a       = mm_prod;
                        mm_b       = base_reg;
                        state_next = ST_MULB;
                    end
                    else
                    begin
                        exp_next   = {exp_reg[NUM_WIDTH-2:0], 1'b0};
                        cnt_next   = cnt_reg - CW'(1);
                        state_next = ST_STEP;
                    end
                end
            end

            ST_MULB:
            begin
                if (mm_done)
                begin
                    acc_next   = mm_prod;
                    exp_next   = {exp_reg[NUM_WIDTH-2:0], 1'b0};
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = ST_STEP;
                end
            end

            // a^d mod n done: check, else start the squaring chain
            ST_TEST:
            begin
                if (acc_reg == N_ONE || acc_reg == nm1)
                begin
                    wit_pass = 1'b1;
                end
                else if (prep_e <= EW'(1))
                begin
                    wit_fail = 1'b1;
                end
                else
                begin
                    ch_next    = prep_e - EW'(1);
                    mm_start   = 1'b1;
                    state_next = ST_CHAIN;
                end
            end

            ST_CHAIN:
            begin
                if (mm_done)
                begin
                    acc_next = mm_prod;
                    if (mm_prod == nm1)
                    begin
                        wit_pass = 1'b1;
                    end
                    else if (ch_reg == EW'(1))
                    begin
                        wit_fail = 1'b1;
                    end
                    else
                    begin
                        ch_next  = ch_reg - EW'(1);
                        mm_start = 1'b1;
                        mm_a     = mm_prod;
                        mm_b     = mm_prod;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Witness outcome: report, or move to the next witness
        if (wit_fail)
        begin
            done_next  = 1'b1;
            res_next   = 1'b0;
            state_next = ST_IDLE;
        end
        else if (wit_pass)
        begin
            if (wit_reg == WIT_LAST)
            begin
                done_next  = 1'b1;
                res_next   = 1'b1;
                state_next = ST_IDLE;
            end
            else
            begin
                wit_next   = wit_reg + 2'd1;
                mm_start   = 1'b1;
                mm_a       = N_ONE;
                mm_b       = NUM_WIDTH'(witness_of(wit_reg + 2'd1));
                state_next = ST_BASE;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            ch_reg    <= '0;
            wit_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
            ch_reg    <= ch_next;
            wit_reg   <= wit_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        base_reg <= base_next;
        acc_reg  <= acc_next;
        exp_reg  <= exp_next;
        res_reg  <= res_next;
    end

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign is_prime = res_reg;

    `MRPT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "transaction accepted but core not busy")
    `MRPT_ASSERT_IMP(a_done_idle, done_reg, !busy, "result strobe while still busy")
    `MRPT_ASSERT_IMP(a_mm_wait, mm_done, (state_reg == ST_BASE) || (state_reg == ST_SQR) || (state_reg == ST_MULB) || (state_reg == ST_CHAIN), "multiplier finished outside a wait state")
    `MRPT_ASSERT_IMP(a_prep_wait, prep_done, state_reg == ST_PREP, "screen finished outside its wait state")

endmodule

FILE: design/mrpt_modmul.sv
// Bit-serial modular multiplier: prod = a * b mod m, one bit of b per cycle.
`timescale 1ns / 1ps
`include "miller_rabin_prime_test_32_core_assert.svh"

module mrpt_modmul
    import mrpt_pkg::*;
#(
    parameter int unsigned NUM_WIDTH = NUM_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [NUM_WIDTH-1:0] a,
    input  logic [NUM_WIDTH-1:0] b,
    input  logic [NUM_WIDTH-1:0] m,
    output logic                 done,
    output logic [NUM_WIDTH-1:0] prod
);

    localparam int unsigned CW = $clog2(NUM_WIDTH + 1);

    logic [NUM_WIDTH-1:0] a_reg, b_reg, m_reg, r_reg;
    logic [NUM_WIDTH-1:0] a_next, b_next, m_next, r_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;

    logic [NUM_WIDTH:0]   dbl, dbl_red, sum;
    logic [NUM_WIDTH:0]   m_ext;
    logic [NUM_WIDTH-1:0] r_step;

    // One interleaved step: r = (2r + bit*a) mod m, with r and a below m
    always_comb
    begin
        m_ext   = {1'b0, m_reg};
        dbl     = {r_reg, 1'b0};
        dbl_red = (dbl >= m_ext) ? (dbl - m_ext) : dbl;
        sum     = dbl_red + (b_reg[NUM_WIDTH-1] ? {1'b0, a_reg} : '0);
        r_step  = (sum >= m_ext) ? NUM_WIDTH'(sum - m_ext) : NUM_WIDTH'(sum);
    end

    // Sequencing of the NUM_WIDTH steps
    always_comb
    begin
        a_next    = a_reg;
        b_next    = b_reg;
        m_next    = m_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            a_next   = a;
            b_next   = b;
            m_next   = m;
            r_next   = '0;
            cnt_next = CW'(NUM_WIDTH);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            r_next   = r_step;
            b_next   = {b_reg[NUM_WIDTH-2:0], 1'b0};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    // Operand and partial result registers
    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        m_reg <= m_next;
        r_reg <= r_next;
    end

    assign done = done_reg;
    assign prod = r_reg;

    `MRPT_ASSERT_IMP(a_prod_reduced, done_reg, r_reg < m_reg, "modmul result not reduced")
    `MRPT_ASSERT_IMP(a_no_restart, start, !run_reg, "modmul restarted while running")

endmodule

FILE: design/mrpt_prep.sv
// Candidate preparation: serial residue mod 3 and split of n-1 into d * 2^e.
`timescale 1ns / 1ps

module mrpt_prep
    import mrpt_pkg::*;
#(
    parameter int unsigned NUM_WIDTH = NUM_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [NUM_WIDTH-1:0]         n,
    output logic                         done,
    output logic                         div3,
    output logic [NUM_WIDTH-1:0]         d,
    output logic [$clog2(NUM_WIDTH)-1:0] e
);

    localparam int unsigned CW = $clog2(NUM_WIDTH + 1);
    localparam int unsigned EW = $clog2(NUM_WIDTH);

    logic [NUM_WIDTH-1:0] nsh_reg, nsh_next;
    logic [NUM_WIDTH-1:0] d_reg, d_next;
    logic [EW-1:0]        e_reg, e_next;
    logic [1:0]           r3_reg, r3_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 run_reg, run_next;
    logic                 done_reg, done_next;

    // Residue update for one more bit, MSB first: (2r + bit) mod 3
    function automatic logic [1:0] mod3_step(input logic [1:0] r, input logic bit_in);
        logic [1:0] q;
        case ({r, bit_in})
            3'b000:  q = 2'd0;
            3'b001:  q = 2'd1;
            3'b010:  q = 2'd2;
            3'b011:  q = 2'd0;
            3'b100:  q = 2'd1;
            3'b101:  q = 2'd2;
            default: q = 2'd0;
        endcase
        return q;
    endfunction

    // One bit per cycle for both the residue and the factor-of-two strip
    always_comb
    begin
        nsh_next  = nsh_reg;
        d_next    = d_reg;
        e_next    = e_reg;
        r3_next   = r3_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            nsh_next = n;
            d_next   = n - NUM_WIDTH'(1);
            e_next   = '0;
            r3_next  = 2'd0;
            cnt_next = CW'(NUM_WIDTH);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            r3_next  = mod3_step(r3_reg, nsh_reg[NUM_WIDTH-1]);
            nsh_next = {nsh_reg[NUM_WIDTH-2:0], 1'b0};
            if (!d_reg[0])
            begin
                d_next = {1'b0, d_reg[NUM_WIDTH-1:1]};
                e_next = e_reg + EW'(1);
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    // Data registers
    always_ff @(posedge clk)
    begin
        nsh_reg <= nsh_next;
        d_reg   <= d_next;
        e_reg   <= e_next;
        r3_reg  <= r3_next;
    end

    assign done = done_reg;
    assign div3 = (r3_reg == 2'd0);
    assign d    = d_reg;
    assign e    = e_reg;

endmodule

FILE: tb/miller_rabin_prime_test_32_core_tb.sv
// Testbench for the Miller-Rabin prime test core: directed and random candidates, scoreboard.
`timescale 1ns / 1ps

module miller_rabin_prime_test_32_core_tb
    import mrpt_pkg::*;
    ();

    localparam int unsigned RANDOM_ITEMS = 75;
    localparam int unsigned STALL_LIMIT  = 60000;
    localparam int unsigned DRAIN_CYCLES = 50;
    localparam logic [31:0] NUM_MASK     = 32'(64'hFFFF_FFFF >> (32 - NUM_WIDTH_DEF));
    // Witnesses, lowest index first: 2, 7, 61
    localparam logic [2:0][31:0] WITNESSES = {32'd61, 32'd7, 32'd2};

    typedef struct {
        logic [31:0] number;
        logic        prime;
    } verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [31:0] candidate = 32'd0;
    logic        busy;
    logic        done;
    logic        is_prime;

    logic [31:0] pending_numbers [$];
    verdict_t    verdict_q [$];
    logic        took_item = 1'b0;
    int unsigned gap_left = 0;
    bit          steady_run = 1'b0;
    int unsigned idle_cycles = 0;
    int unsigned mismatches = 0;
    int unsigned checked = 0;
    int unsigned primes_seen = 0;
    int unsigned accepted = 0;

    miller_rabin_prime_test_32_core #(
        .NUM_WIDTH (NUM_WIDTH_DEF)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .candidate (candidate),
        .done      (done),
        .is_prime  (is_prime)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ---------------- primality predictor ----------------

    function automatic logic [31:0] mod_mul(input logic [31:0] a, input logic [31:0] b,
                                            input logic [31:0] m);
        logic [63:0] prod;
        prod = {32'd0, a} * {32'd0, b};
        return 32'(prod % {32'd0, m});
    endfunction

    // Square-and-multiply, LSB first
    function automatic logic [31:0] mod_pow(input logic [31:0] base, input logic [31:0] expo,
                                            input logic [31:0] m);
        logic [31:0] acc;
        logic [31:0] sq;
        logic [31:0] e;
        acc = 32'd1 % m;
        sq  = base % m;
        e   = expo;
        while (e != 32'd0)
        begin
            if (e[0])
                acc = mod_mul(acc, sq, m);
            sq = mod_mul(sq, sq, m);
            e  = e >> 1;
        end
        return acc;
    endfunction

    // Strong probable prime check for one witness; n odd, n >= 5
    function automatic bit survives_witness(input logic [31:0] n, input logic [31:0] a,
                                            input logic [31:0] d, input int twos);
        logic [31:0] x;
        int          i;
        x = mod_pow(a, d, n);
        if (x == 32'd1 || x == n - 32'd1)
            return 1'b1;
        for (i = 1; i < twos; i++)
        begin
            x = mod_mul(x, x, n);
            if (x == n - 32'd1)
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic bit prime_verdict(input logic [31:0] raw);
        logic [31:0] n;
        logic [31:0] d;
        int          twos;
        int          w;
        n = raw & NUM_MASK;
        if (n < 32'd2)
            return 1'b0;
        if (n == PRIME_TWO || n == PRIME_THREE)
            return 1'b1;
        if (!n[0])
            return 1'b0;
        if (n % 32'd3 == 32'd0)
            return 1'b0;
        for (w = 0; w < 3; w++)
            if (n == WITNESSES[w])
                return 1'b1;
        // n-1 = d * 2^twos, d odd
        d    = n - 32'd1;
        twos = 0;
        while (!d[0])
        begin
            d = d >> 1;
            twos++;
        end
        for (w = 0; w < 3; w++)
            if (!survives_witness(n, WITNESSES[w], d, twos))
                return 1'b0;
        return 1'b1;
    endfunction

    // ---------------- stimulus ----------------

    function automatic logic [31:0] prime_at_or_after(input logic [31:0] start_point);
        logic [31:0] x;
        x = start_point | 32'd1;
        while (!prime_verdict(x))
            x = x + 32'd2;
        return x;
    endfunction

    // Mostly primes and hard odd numbers, so the witness loop gets real work
    function automatic logic [31:0] random_candidate();
        int unsigned pick;
        logic [31:0] p;
        logic [31:0] q;
        logic [31:0] x;
        pick = $urandom_range(0, 99);
        if (pick < 35)
            return prime_at_or_after($urandom);
        else if (pick < 60)
        begin
            // odd, not a multiple of three
            x = $urandom | 32'd1;
            while (x % 32'd3 == 32'd0)
                x = x + 32'd2;
            return x;
        end
        else if (pick < 75)
        begin
            p = prime_at_or_after($urandom_range(3, 60000));
            q = prime_at_or_after($urandom_range(3, 60000));
            return p * q;
        end
        else if (pick < 82)
            return $urandom_range(0, 64);
        else
            return $urandom;
    endfunction

    // Mostly back-to-back, sometimes short, rarely long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (steady_run || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 20);
        else
            return $urandom_range(50, 300);
    endfunction

    // ---------------- driver ----------------

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            // hold the current transaction until the core takes it
            if (!start || took_item)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    start <= 1'b0;
                end
                else if (pending_numbers.size() > 0)
                begin
                    if ($urandom_range(0, 9) == 0)
                        steady_run = !steady_run;
                    candidate <= pending_numbers.pop_front();
                    start     <= 1'b1;
                    gap_left   = pick_gap();
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // ---------------- monitor and scoreboard ----------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            took_item <= start && !busy;
            // result first: it belongs to an older transaction
            if (done)
            begin
                if (verdict_q.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected result: expected none, actual is_prime=%0b",
                             $realtime, is_prime);
                end
                else
                begin
                    verdict_t want;
                    want = verdict_q.pop_front();
                    checked++;
                    if (is_prime !== want.prime)
                    begin
                        mismatches++;
                        $display("%0t: candidate %0d: expected is_prime=%0b, actual %0b",
                                 $realtime, want.number, want.prime, is_prime);
                    end
                end
            end
            if (start && !busy)
            begin
                verdict_t item;
                item.number = candidate;
                item.prime  = prime_verdict(candidate);
                verdict_q.push_back(item);
                accepted++;
                if (item.prime)
                    primes_seen++;
            end
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $realtime, STALL_LIMIT);
            $display("miller_rabin_prime_test_32_core regression: fail");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ---------------- sequence ----------------

    initial
    begin
        int unsigned k;
        // edge values, witnesses, pseudoprimes to small bases, long n-1 power of two
        pending_numbers = '{
            32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7, 32'd9, 32'd61, 32'd121,
            32'd561, 32'd1729, 32'd2047, 32'd3277, 32'd65537, 32'd25326001,
            32'd3215031751, 32'd3221225473, 32'd2147483647, 32'h8000_0000,
            32'd4294967291, 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hAAAA_AAAB, 32'h5555_5555
        };
        for (k = 0; k < RANDOM_ITEMS; k++)
            pending_numbers.push_back(random_candidate());

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // everything sent and every verdict back
        while (pending_numbers.size() != 0 || start || verdict_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Tested %0d candidates (%0d prime by prediction), %0d results checked.",
                 accepted, primes_seen, checked);
        $display("Mismatches: %0d", mismatches);
        if (mismatches == 0 && verdict_q.size() == 0)
            $display("miller_rabin_prime_test_32_core regression: pass");
        else
            $display("miller_rabin_prime_test_32_core regression: fail");
        $finish;
    end

endmodule
